### rtl/iobc_pkg.sv
`default_nettype none

package iobc_pkg;

  // Function codes of an input item
  localparam logic [2:0] FuncCtrlWr = 3'd0;
  localparam logic [2:0] FuncCtrlRd = 3'd1;
  localparam logic [2:0] FuncDataWr = 3'd2;
  localparam logic [2:0] FuncDataRd = 3'd3;
  localparam logic [2:0] FuncTick   = 3'd4;

  // Controller command bytes
  localparam logic [7:0] CmdCoinage = 8'h01;
  localparam logic [7:0] CmdCredit  = 8'h02;
  localparam logic [7:0] CmdSwitch  = 8'h05;

  localparam logic [2:0] CoinageArgs = 3'd4;
  localparam logic [6:0] CreditMax   = 7'd99;
  localparam int unsigned DivBaseLog = 5;   // half period = 32 << shift
  localparam int unsigned DivW       = 13;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_CREDIT = 2'd1,
    MODE_SWITCH = 2'd2
  } mode_e;

  // Request from the bridge to the coin controller for one item
  typedef struct packed {
    logic       cmd_we;
    logic       rd_en;
    logic       tick;
    logic [7:0] data;
    logic [7:0] sw_a;
    logic [7:0] sw_b;
  } ctl_req_t;

  // Two-digit BCD of a value up to 99
  function automatic logic [7:0] to_bcd(input logic [6:0] val);
    logic [3:0] tens;
    logic [6:0] ones;
    tens = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (val >= 7'(10 * k)) begin
        tens = 4'(k);
      end
    end
    ones = val - 7'(tens) * 7'd10;
    return {tens, ones[3:0]};
  endfunction

endpackage

`default_nettype wire

### rtl/iobc_in_if.sv
`default_nettype none

interface iobc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] data;
  logic [5:0] cycles;
  logic [7:0] switches_a;
  logic [7:0] switches_b;

  modport source (output valid, func, data, cycles, switches_a, switches_b, input ready);
  modport sink   (input valid, func, data, cycles, switches_a, switches_b, output ready);
endinterface

`default_nettype wire

### rtl/iobc_out_if.sv
`default_nettype none

interface iobc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       nmi_pulse;
  logic       select_line;

  modport source (output valid, read_data, nmi_pulse, select_line, input ready);
  modport sink   (input valid, read_data, nmi_pulse, select_line, output ready);
endinterface

`default_nettype wire

### rtl/iobc_coin_ctrl.sv
`default_nettype none

module iobc_coin_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire iobc_pkg::ctl_req_t req_i,
  output logic [7:0]            rdata_o
);

  iobc_pkg::mode_e mode_q, mode_d;
  logic [2:0] pend_q, pend_d;
  logic [1:0] ridx_q, ridx_d;
  logic [6:0] credit_q, credit_d;
  logic [7:0] prev_q, prev_d;

  logic [7:0] inv_a, inv_b, bcd;
  logic [2:0] rose;
  logic [8:0] credit_sum;

  assign inv_a = ~req_i.sw_a;
  assign inv_b = ~req_i.sw_b;
  assign bcd   = iobc_pkg::to_bcd((credit_q > iobc_pkg::CreditMax) ?
                                  iobc_pkg::CreditMax : credit_q);
  assign rose  = req_i.sw_b[6:4] & ~prev_q[6:4];
  assign credit_sum = {2'b00, credit_q} + 9'(rose[0]) + 9'(rose[1]) + 9'(rose[2]);

  // Byte handed out for the current read position
  always_comb begin
    if (mode_q == iobc_pkg::MODE_CREDIT) begin
      case (ridx_q)
        2'd0:    rdata_o = bcd;
        2'd1:    rdata_o = inv_a;
        default: rdata_o = inv_b;
      endcase
    end else begin
      case (ridx_q)
        2'd0:    rdata_o = inv_a;
        2'd1:    rdata_o = inv_b;
        default: rdata_o = 8'hFF;
      endcase
    end
  end

  always_comb begin
    mode_d   = mode_q;
    pend_d   = pend_q;
    ridx_d   = ridx_q;
    credit_d = credit_q;
    prev_d   = prev_q;
    if (req_i.cmd_we) begin
      if (pend_q != 3'd0) begin
        pend_d = pend_q - 3'd1;  // drop coinage byte
      end else begin
        unique case (req_i.data)
          iobc_pkg::CmdCoinage: pend_d = iobc_pkg::CoinageArgs;
          iobc_pkg::CmdCredit: begin
            mode_d = iobc_pkg::MODE_CREDIT;
            ridx_d = 2'd0;
          end
          iobc_pkg::CmdSwitch: begin
            mode_d = iobc_pkg::MODE_SWITCH;
            ridx_d = 2'd0;
          end
          default: ;
        endcase
      end
    end
    if (req_i.rd_en) begin
      ridx_d = (ridx_q >= 2'd2) ? 2'd0 : ridx_q + 2'd1;
    end
    if (req_i.tick) begin
      if (mode_q == iobc_pkg::MODE_CREDIT) begin
        credit_d = (credit_sum > 9'(iobc_pkg::CreditMax)) ?
                   iobc_pkg::CreditMax : credit_sum[6:0];
      end
      prev_d = req_i.sw_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= iobc_pkg::MODE_NONE;
      pend_q   <= 3'd0;
      ridx_q   <= 2'd0;
      credit_q <= 7'd0;
      prev_q   <= 8'd0;
    end else begin
      mode_q   <= mode_d;
      pend_q   <= pend_d;
      ridx_q   <= ridx_d;
      credit_q <= credit_d;
      prev_q   <= prev_d;
    end
  end

endmodule

`default_nettype wire

### rtl/io_bridge_with_coin_credit_controller_core.sv
`default_nettype none

// I/O bridge with a coin and switch controller behind it.
//
// in_i  : one item per bus access or tick (func, data, cycles, switch bytes).
//         An item is taken at a clock edge with valid and ready high.
// out_o : exactly one result item per input item, in order: read byte,
//         NMI pulse flag and the chip-select strobe level after the item.
// cfg   : cfg_we_i writes cfg_wdata_i into the sub-CPU hold bit, which
//         masks NMI pulses. Write it only while no item is in flight.
//
// An accepted item waits in the input register until the output register
// is free; then the bridge and controller logic acts on it and updates all
// state, and its result is loaded into the output register. Throughput is
// one item per cycle while the receiver does not stall; the divider takes at
// most one half-period step per tick, so no item needs a second pass. Reset
// clears all state but the payload registers and sets the hold bit. When the
// receiver stalls, the result holds in the output register and one more
// item can wait in the input register; ready drops only when both are full.
module io_bridge_with_coin_credit_controller_core (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  iobc_in_if.sink     in_i,
  iobc_out_if.source  out_o,
  input  wire logic   cfg_we_i,
  input  wire logic   cfg_wdata_i
);

  localparam int unsigned DivW = iobc_pkg::DivW;

  // Input register
  logic       s1_v_q;
  logic [2:0] func_q;
  logic [7:0] data_q;
  logic [5:0] cycles_q;
  logic [7:0] sw_a_q;
  logic [7:0] sw_b_q;

  // Bridge state
  logic            held_q;
  logic [7:0]      ctrl_q, ctrl_d;
  logic [DivW-1:0] div_q, div_d;
  logic            phase_q, phase_d;
  logic            skip_q, skip_d;
  logic            sel_q, sel_d;

  // Output register
  logic       out_v_q;
  logic [7:0] rd_q;
  logic       nmi_q;
  logic       sel_out_q;

  logic out_free, s1_fire, in_fire;
  logic [7:0] rd_d;
  logic       nmi_d;
  logic [2:0] shift;
  logic [DivW-1:0] half, div_sum;
  logic [7:0] ctl_rdata;
  iobc_pkg::ctl_req_t ctl_req;

  assign out_free  = !out_v_q || out_o.ready;
  assign s1_fire   = s1_v_q && out_free;
  assign in_i.ready = !s1_v_q || out_free;
  assign in_fire   = in_i.valid && in_i.ready;

  assign shift   = ctrl_q[7:5];
  assign half    = DivW'(1) << (DivW'(iobc_pkg::DivBaseLog) + DivW'(shift));
  assign div_sum = div_q + DivW'(cycles_q);

  // Controller access: commands and reads are selected when bit 0 is set, bit 4 gives direction; ticks always pass
  always_comb begin
    ctl_req.cmd_we = s1_fire && (func_q == iobc_pkg::FuncDataWr) &&
                     !ctrl_q[4] && ctrl_q[0];
    ctl_req.rd_en  = s1_fire && (func_q == iobc_pkg::FuncDataRd) &&
                     ctrl_q[4] && ctrl_q[0];
    ctl_req.tick   = s1_fire && (func_q == iobc_pkg::FuncTick);
    ctl_req.data   = data_q;
    ctl_req.sw_a   = sw_a_q;
    ctl_req.sw_b   = sw_b_q;
  end

  iobc_coin_ctrl u_coin_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ctl_req),
    .rdata_o (ctl_rdata)
  );

  always_comb begin
    ctrl_d  = ctrl_q;
    div_d   = div_q;
    phase_d = phase_q;
    skip_d  = skip_q;
    sel_d   = sel_q;
    rd_d    = 8'h00;
    nmi_d   = 1'b0;
    if (s1_fire) begin
      case (func_q)
        iobc_pkg::FuncCtrlWr: begin
          ctrl_d  = data_q;
          div_d   = '0;
          phase_d = 1'b0;
          skip_d  = data_q[4] && (data_q[7:5] != 3'd0);
          if (data_q[7:5] == 3'd0) begin
            sel_d = 1'b0;
          end
        end
        iobc_pkg::FuncCtrlRd: rd_d = ctrl_q;
        iobc_pkg::FuncDataRd: begin
          if (ctrl_q[4]) begin
            rd_d = ctrl_q[0] ? ctl_rdata : 8'hFF;
          end
        end
        iobc_pkg::FuncTick: begin
          // Count stays below half, and cycles below the smallest half,
          // so at most one strobe edge per tick.
          if (shift != 3'd0) begin
            if (div_sum >= half) begin
              div_d   = div_sum - half;
              phase_d = !phase_q;
              if (!phase_q) begin
                sel_d = 1'b0;
              end else begin
                sel_d  = 1'b1;
                skip_d = 1'b0;
                nmi_d  = !skip_q && !held_q;
              end
            end else begin
              div_d = div_sum;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
      held_q    <= 1'b1;
      ctrl_q    <= 8'h00;
      div_q     <= '0;
      phase_q   <= 1'b0;
      skip_q    <= 1'b0;
      sel_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        held_q <= cfg_wdata_i;
      end
      if (in_i.ready) begin
        s1_v_q <= in_i.valid;
      end
      if (out_free) begin
        out_v_q <= s1_v_q;
      end
      ctrl_q  <= ctrl_d;
      div_q   <= div_d;
      phase_q <= phase_d;
      skip_q  <= skip_d;
      sel_q   <= sel_d;
    end
  end

  // Payload registers: load on handshake, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q   <= in_i.func;
      data_q   <= in_i.data;
      cycles_q <= in_i.cycles;
      sw_a_q   <= in_i.switches_a;
      sw_b_q   <= in_i.switches_b;
    end
    if (s1_fire) begin
      rd_q      <= rd_d;
      nmi_q     <= nmi_d;
      sel_out_q <= sel_d;
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.read_data   = rd_q;
  assign out_o.nmi_pulse   = nmi_q;
  assign out_o.select_line = sel_out_q;

  // An NMI always comes with the strobe raised
  a_nmi_sel : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && nmi_q |-> sel_out_q)
    else $error("NMI result without select strobe");

  // Divider count stays below the half period while running
  a_div_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (shift != 3'd0) |-> (div_q < half))
    else $error("divider count out of range");

  // An empty output register never blocks the input side
  a_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_v_q |-> in_i.ready)
    else $error("input stalled with empty output register");

  // A control write that stops the divider drops the select line
  a_sel_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && (func_q == iobc_pkg::FuncCtrlWr) && (data_q[7:5] == 3'd0)
    |=> !sel_q && (div_q == '0))
    else $error("select not cleared by control write");

endmodule

`default_nettype wire
